### src/dsi_pkg.sv
// ----------------------------------------------------------------------------
// dsi_pkg: shared types and codes for the sorted digest set insert block
// Widths of the item fields, status and selector codes, and the structs that
// travel between the top level, the set rows and the cells.
// ----------------------------------------------------------------------------
package dsi_pkg;

   localparam int WORD_W     = 64;
   localparam int DIGEST_W   = 4 * WORD_W;
   localparam int SEL_W      = 2;
   localparam int STATUS_W   = 2;
   localparam int SLOT_W     = 6;
   localparam int FILL_OUT_W = 7;
   localparam int RSP_DATA_W = 16;

   // set selector codes
   localparam logic [SEL_W-1:0] SEL_PROFILE   = 2'd0;
   localparam logic [SEL_W-1:0] SEL_VECTOR    = 2'd1;
   localparam logic [SEL_W-1:0] SEL_REFERENCE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

   // word 0 sits in the top bits so a plain unsigned compare gives set order
   typedef logic [DIGEST_W-1:0] digest_type;

   // per-row commands
   typedef struct packed {
      logic cmp_en;    // compare the offered digest, latch flags
      logic shift_en;  // commit the insert using the latched flags
   } cell_ctl_type;

   // what one cell hands to its right-hand neighbour
   typedef struct packed {
      digest_type digest;
      logic       ins;    // this cell takes part in the insert shift
      logic       valid;
   } link_type;

   // row summary seen by the top level
   typedef struct packed {
      logic                  dup;
      logic                  full;
      logic [SLOT_W-1:0]     slot;
      logic [FILL_OUT_W-1:0] fill;
   } row_status_type;

endpackage

### src/sorted_digest_set_insert.sv
// ----------------------------------------------------------------------------
// sorted_digest_set_insert: three bounded sorted sets of 256-bit digests
// Each item names a set and offers a digest; the result reports inserted,
// duplicate or full with the insert position and the new fill count.
// ----------------------------------------------------------------------------
//  channel   direction  tdata                           tuser
//  req_      in         digest words 0..3 (256 bits)    list_select (2)
//  rsp_      out        slot (6), fill_count (7)        status (2)
//
//  An item passes the accept cycle, which compares the offered digest in
//  every cell of the selected row, then ST_DONE, which commits the shift and
//  loads the result register. One item is in work at a time.
//  A stalled result holds the commit cycle until the output register frees.
//  Reset clears the fill counts and valid bits; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sorted_digest_set_insert
   import dsi_pkg::*;
#(
   parameter int PROFILE_CAPACITY   = 64,
   parameter int VECTOR_CAPACITY    = 64,
   parameter int REFERENCE_CAPACITY = 64
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [DIGEST_W-1:0]   req_tdata,   // digest_word0, _word1, _word2, _word3
   input  logic [SEL_W-1:0]      req_tuser,   // list_select
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slot, fill_count, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser    // status
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DONE = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [SEL_W-1:0]      sel_ff;
   digest_type            digest_ff;
   digest_type            req_digest;
   logic                  accept;
   logic                  commit;
   logic                  out_free;
   logic                  insert;
   row_status_type        row_stat [3];
   row_status_type        cur;
   cell_ctl_type          ctl [3];
   logic [STATUS_W-1:0]   status;
   logic [SLOT_W-1:0]     slot;
   logic [FILL_OUT_W-1:0] fill;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [FILL_OUT_W-1:0] rsp_fill_ff;

   // word 0 is the most significant for ordering
   assign req_digest = {req_tdata[WORD_W-1:0],
                        req_tdata[2*WORD_W-1:WORD_W],
                        req_tdata[3*WORD_W-1:2*WORD_W],
                        req_tdata[4*WORD_W-1:3*WORD_W]};

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign commit     = (state_ff == ST_DONE) && out_free;

   // summary of the selected row
   always_comb begin
      cur = '0;
      case (sel_ff)
         SEL_PROFILE:   cur = row_stat[0];
         SEL_VECTOR:    cur = row_stat[1];
         SEL_REFERENCE: cur = row_stat[2];
         default:       cur = '0;
      endcase
   end

   // result; the unused selector reports full with a zero count
   always_comb begin
      insert = 1'b0;
      status = STATUS_FULL;
      slot   = '0;
      fill   = cur.fill;
      if (sel_ff != SEL_PROFILE && sel_ff != SEL_VECTOR && sel_ff != SEL_REFERENCE) begin
         fill = '0;
      end else if (cur.full) begin
         status = STATUS_FULL;
      end else if (cur.dup) begin
         status = STATUS_DUPLICATE;
      end else begin
         insert = 1'b1;
         status = STATUS_INSERTED;
         slot   = cur.slot;
         fill   = cur.fill + FILL_OUT_W'(1);
      end
   end

   // row commands
   always_comb begin
      ctl[0] = '{cmp_en: accept && req_tuser == SEL_PROFILE,
                 shift_en: commit && insert && sel_ff == SEL_PROFILE};
      ctl[1] = '{cmp_en: accept && req_tuser == SEL_VECTOR,
                 shift_en: commit && insert && sel_ff == SEL_VECTOR};
      ctl[2] = '{cmp_en: accept && req_tuser == SEL_REFERENCE,
                 shift_en: commit && insert && sel_ff == SEL_REFERENCE};
   end

   dsi_row #(.CAP(PROFILE_CAPACITY)) u_profile (
      .clock (clock), .reset (reset), .ctl (ctl[0]),
      .cmp_digest (req_digest), .new_digest (digest_ff), .status (row_stat[0])
   );

   dsi_row #(.CAP(VECTOR_CAPACITY)) u_vector (
      .clock (clock), .reset (reset), .ctl (ctl[1]),
      .cmp_digest (req_digest), .new_digest (digest_ff), .status (row_stat[1])
   );

   dsi_row #(.CAP(REFERENCE_CAPACITY)) u_reference (
      .clock (clock), .reset (reset), .ctl (ctl[2]),
      .cmp_digest (req_digest), .new_digest (digest_ff), .status (row_stat[2])
   );

   // sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_DONE;
         ST_DONE: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         sel_ff    <= req_tuser;
         digest_ff <= req_digest;
      end
      if (commit) begin
         rsp_status_ff <= status;
         rsp_slot_ff   <= slot;
         rsp_fill_ff   <= fill;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {(RSP_DATA_W - SLOT_W - FILL_OUT_W)'(0), rsp_fill_ff, rsp_slot_ff};

endmodule

### src/dsi_cell.sv
// ----------------------------------------------------------------------------
// dsi_cell: one entry of a sorted digest row
// Holds one digest and its valid bit, compares it with the offered digest and
// on an insert takes either its left neighbour's digest or the new one.
// ----------------------------------------------------------------------------
module dsi_cell
   import dsi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cell_ctl_type ctl,
   input  digest_type   cmp_digest,
   input  digest_type   new_digest,
   input  link_type     left,
   output link_type     right,
   output logic         eq
);

   digest_type digest_ff, digest_in;
   logic       valid_ff, valid_in;
   logic       ins_ff, ins_in;
   logic       eq_ff, eq_in;

   // compare on accept, shift on commit
   always_comb begin
      digest_in = digest_ff;
      valid_in  = valid_ff;
      ins_in    = ins_ff;
      eq_in     = eq_ff;
      if (ctl.cmp_en) begin
         eq_in  = valid_ff && (digest_ff == cmp_digest);
         ins_in = !valid_ff || (digest_ff > cmp_digest);
      end
      if (ctl.shift_en && ins_ff) begin
         digest_in = left.ins ? left.digest : new_digest;
         valid_in  = valid_ff | left.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         ins_ff   <= 1'b0;
         eq_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         ins_ff   <= ins_in;
         eq_ff    <= eq_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      digest_ff <= digest_in;
   end

   assign right = '{digest: digest_ff, ins: ins_ff, valid: valid_ff};
   assign eq    = eq_ff;

endmodule

### src/dsi_row.sv
// ----------------------------------------------------------------------------
// dsi_row: one bounded sorted digest set
// A chain of cells plus the fill counter. The latched cell flags give the
// duplicate hit and the insert position; shift commits the insert.
// ----------------------------------------------------------------------------
module dsi_row
   import dsi_pkg::*;
#(
   parameter int CAP = 64
)
(
   input  logic           clock,
   input  logic           reset,
   input  cell_ctl_type   ctl,
   input  digest_type     cmp_digest,
   input  digest_type     new_digest,
   output row_status_type status
);

   localparam int FILL_W = $clog2(CAP + 1);

   link_type          link [CAP+1];
   logic [CAP-1:0]    eq;
   logic [CAP-1:0]    first;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SLOT_W-1:0] slot;

   // left end: always valid, never shifting
   assign link[0] = '{digest: '0, ins: 1'b0, valid: 1'b1};

   for (genvar i = 0; i < CAP; i++) begin : g_cell
      dsi_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .cmp_digest (cmp_digest),
         .new_digest (new_digest),
         .left       (link[i]),
         .right      (link[i+1]),
         .eq         (eq[i])
      );
      // insert flags form a thermometer; its edge is the insert position
      assign first[i] = link[i+1].ins & ~link[i].ins;
   end

   // encode the one-hot insert position
   always_comb begin
      slot = '0;
      for (int i = 0; i < CAP; i++) begin
         if (first[i]) begin
            slot = slot | SLOT_W'(i);
         end
      end
   end

   // fill counter
   always_comb begin
      fill_in = fill_ff;
      if (ctl.shift_en) begin
         fill_in = fill_ff + FILL_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   assign status = '{dup:  |eq,
                     full: (fill_ff >= FILL_W'(CAP)),
                     slot: slot,
                     fill: FILL_OUT_W'(fill_ff)};

endmodule

### src/dsi_checker.sv
// ----------------------------------------------------------------------------
// dsi_checker: port-level checks for sorted_digest_set_insert
// Watches the two channels and flags results or handshakes that the block
// can never legally produce.
// ----------------------------------------------------------------------------
module dsi_checker
   import dsi_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [STATUS_W-1:0]   rsp_tuser
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // only the three status codes appear
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == STATUS_INSERTED || rsp_tuser == STATUS_DUPLICATE
                      || rsp_tuser == STATUS_FULL))
      else $error("unknown status code");

   // slot is zero unless the digest went in
   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_INSERTED |-> rsp_tdata[SLOT_W-1:0] == '0)
      else $error("slot set on a refused item");

   // one item in work: busy in the cycle after an accept
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken during commit");

endmodule

bind sorted_digest_set_insert dsi_checker u_dsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

### tb/sorted_digest_set_insert_tb.sv
// ----------------------------------------------------------------------------
// sorted_digest_set_insert_tb: self-checking bench for the digest set insert
// Drives request items into the three sets, keeps its own sorted copy of each
// set to work out status, slot and fill count, and checks every response
// item in order. Both channels idle at random, with one unbroken stretch.
// ----------------------------------------------------------------------------
module sorted_digest_set_insert_tb
   import dsi_pkg::*;
();

   localparam int SET_CAPACITY = 64;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int REPORT_MAX   = 10;

   // selector value that names no set
   localparam logic [SEL_W-1:0] SEL_UNUSED = 2'd3;

   typedef struct {
      logic [STATUS_W-1:0]   status;
      logic [SLOT_W-1:0]     slot;
      logic [FILL_OUT_W-1:0] fill;
   } outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DIGEST_W-1:0]   req_tdata;   // digest_word0, _word1, _word2, _word3
   logic [SEL_W-1:0]      req_tuser;   // list_select
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // slot, fill_count, zero pad
   logic [STATUS_W-1:0]   rsp_tuser;   // status

   // sorted contents of profiles, vectors and references
   // (word 0 in the top bits, so a plain unsigned compare gives set order)
   digest_type  set_entries[0:2][$];
   outcome_type pending_outcomes[$];
   int          mismatch_count;
   int          cycle_count;
   bit          steady_flow;

   sorted_digest_set_insert #(
      .PROFILE_CAPACITY   (SET_CAPACITY),
      .VECTOR_CAPACITY    (SET_CAPACITY),
      .REFERENCE_CAPACITY (SET_CAPACITY)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // response side back-pressure
   always @(posedge clock) begin
      rsp_tready <= steady_flow || ($urandom_range(99) >= 7);
   end

   // apply one insert to the local sets and return what the block must report
   function automatic outcome_type insert_digest(logic [SEL_W-1:0] sel, digest_type key);
      outcome_type res;
      int          n;
      int          pos;
      bit          dup;
      res.status = STATUS_FULL;
      res.slot   = '0;
      res.fill   = '0;
      if (sel == SEL_UNUSED) return res;
      n = set_entries[sel].size();
      res.fill = n[FILL_OUT_W-1:0];
      // a full set refuses before any duplicate check
      if (n >= SET_CAPACITY) return res;
      pos = n;
      dup = 1'b0;
      for (int i = 0; i < n; i++) begin
         if (set_entries[sel][i] == key) dup = 1'b1;
         else if (set_entries[sel][i] > key && pos == n) pos = i;
      end
      if (dup) begin
         res.status = STATUS_DUPLICATE;
         return res;
      end
      set_entries[sel].insert(pos, key);
      res.status = STATUS_INSERTED;
      res.slot   = pos[SLOT_W-1:0];
      res.fill   = FILL_OUT_W'(set_entries[sel].size());
      return res;
   endfunction

   // random word with extra weight on the extremes
   function automatic logic [WORD_W-1:0] random_word();
      int pick;
      pick = $urandom_range(99);
      if (pick < 10) return '0;
      if (pick < 20) return '1;
      return {$urandom, $urandom};
   endfunction

   function automatic digest_type random_digest();
      return {random_word(), random_word(), random_word(), random_word()};
   endfunction

   // offer one item; expectation recorded at the accepting edge
   task automatic send_digest(logic [SEL_W-1:0] sel, digest_type key);
      if (!steady_flow && $urandom_range(99) < 7) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < 7) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= sel;
      req_tdata  <= {key[63:0], key[127:64], key[191:128], key[255:192]};
      do @(posedge clock); while (!req_tready);
      pending_outcomes.push_back(insert_digest(sel, key));
   endtask

   // response checker
   always @(posedge clock) begin
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_outcomes.size() == 0) begin
            if (mismatch_count < REPORT_MAX)
               $display("unexpected response item: status %0d slot %0d fill %0d",
                        rsp_tuser, rsp_tdata[5:0], rsp_tdata[12:6]);
            mismatch_count++;
         end else begin
            want = pending_outcomes.pop_front();
            if (rsp_tuser !== want.status || rsp_tdata[5:0] !== want.slot ||
                rsp_tdata[12:6] !== want.fill) begin
               if (mismatch_count < REPORT_MAX)
                  $display({"response mismatch: expected status %0d slot %0d ",
                            "fill %0d, got %0d %0d %0d"},
                           want.status, want.slot, want.fill,
                           rsp_tuser, rsp_tdata[5:0], rsp_tdata[12:6]);
               mismatch_count++;
            end
         end
      end
   end

   // ordering extremes, duplicates, set independence and the unused selector
   task automatic test_directed_orderings;
      send_digest(SEL_PROFILE, '0);
      send_digest(SEL_PROFILE, '1);
      send_digest(SEL_PROFILE, '0);
      send_digest(SEL_PROFILE, {64'h8000_0000_0000_0000, 192'd0});
      send_digest(SEL_PROFILE, {64'h7FFF_FFFF_FFFF_FFFF, {192{1'b1}}});
      send_digest(SEL_PROFILE, {192'd0, 64'd1});
      send_digest(SEL_PROFILE, {192'd0, 64'd1});
      send_digest(SEL_PROFILE, {{192{1'b1}}, 64'hFFFF_FFFF_FFFF_FFFE});
      send_digest(SEL_VECTOR, '0);
      send_digest(SEL_VECTOR, {4{64'h5555_5555_5555_5555}});
      send_digest(SEL_VECTOR, {4{64'hAAAA_AAAA_AAAA_AAAA}});
      send_digest(SEL_VECTOR, {64'h5555_5555_5555_5555, 64'd0, 64'd0, 64'd0});
      send_digest(SEL_REFERENCE, '1);
      send_digest(SEL_REFERENCE, '0);
      send_digest(SEL_REFERENCE, {64'd0, 64'd0, 64'd1, 64'd0});
      send_digest(SEL_REFERENCE, '1);
      send_digest(SEL_UNUSED, '1);
      send_digest(SEL_UNUSED, '0);
      send_digest(SEL_UNUSED, {4{64'hAAAA_AAAA_AAAA_AAAA}});
   endtask

   // mostly re-offers and near neighbours so the sets fill over the run
   task automatic test_random_mix;
      logic [SEL_W-1:0] sel;
      digest_type       key;
      int               pick;
      int               w;
      for (int n = 0; n < 1900; n++) begin
         steady_flow = (n >= 600 && n < 900);
         pick = $urandom_range(99);
         if (pick < 5) sel = SEL_UNUSED;
         else sel = SEL_W'($urandom_range(2));
         key = random_digest();
         if (sel != SEL_UNUSED && set_entries[sel].size() > 0) begin
            pick = $urandom_range(99);
            if (pick < 91)
               key = set_entries[sel][$urandom_range(set_entries[sel].size() - 1)];
            if (pick >= 85 && pick < 91) begin
               w = $urandom_range(3);
               if ($urandom_range(1)) key[w*WORD_W +: WORD_W] += WORD_W'(1);
               else key[w*WORD_W +: WORD_W] -= WORD_W'(1);
            end
         end
         send_digest(sel, key);
      end
      steady_flow = 1'b0;
   endtask

   // fill every set, take the top slot, then hit the full case
   task automatic test_capacity_limits;
      logic [SEL_W-1:0] sel;
      for (int s = 0; s < 3; s++) begin
         sel = SEL_W'(s);
         while (set_entries[sel].size() < SET_CAPACITY - 1)
            send_digest(sel, random_digest());
         if (set_entries[sel].size() < SET_CAPACITY) send_digest(sel, '1);
         while (set_entries[sel].size() < SET_CAPACITY)
            send_digest(sel, random_digest());
         send_digest(sel, set_entries[sel][0]);
         send_digest(sel, set_entries[sel][SET_CAPACITY - 1]);
         send_digest(sel, random_digest());
      end
   endtask

   initial begin
      reset          <= 1'b1;
      req_tvalid     <= 1'b0;
      req_tdata      <= '0;
      req_tuser      <= '0;
      steady_flow    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed_orderings();
      test_random_mix();
      test_capacity_limits();

      // drain outstanding responses, then allow for any straggler
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_outcomes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
